>>> rtl/infix_expression_evaluator_top_defines.svh
// Assertion macros for the checker file of the infix evaluator.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef INFIX_EXPRESSION_EVALUATOR_TOP_DEFINES_SVH
`define INFIX_EXPRESSION_EVALUATOR_TOP_DEFINES_SVH

// Checked only outside reset.
`define IEE_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define IEE_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/iee_pkg.sv
// Shared types and constants of the infix expression evaluator.
// No dependencies; the front, queue, divider, back end and top import this package.
package iee_pkg;

    localparam int DATA_WIDTH  = 32;
    localparam int VALUE_WIDTH = 32;
    localparam int CHAR_WIDTH  = 8;
    localparam int DIGIT_WIDTH = 4;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);

    // character codes
    localparam logic [CHAR_WIDTH-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_WIDTH-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_WIDTH-1:0] CH_STAR  = 8'h2A;
    localparam logic [CHAR_WIDTH-1:0] CH_SLASH = 8'h2F;
    localparam logic [CHAR_WIDTH-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_WIDTH-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_WIDTH-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_WIDTH-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_WIDTH-1:0] CH_CR    = 8'h0D;

    typedef logic [DATA_WIDTH-1:0] word_t;

    typedef enum logic [2:0] {
        OP_PLUS,
        OP_MINUS,
        OP_TIMES,
        OP_DIVIDE,
        OP_OTHER
    } op_t;

    // what the front hands to the back
    typedef enum logic [1:0] {
        CMD_DIGIT,
        CMD_OPER,
        CMD_FLUSH
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t              kind;
        logic [DIGIT_WIDTH-1:0] digit;
        op_t                    op;
        logic                   last;
    } cmd_t;

    typedef struct packed {
        logic  start;
        word_t dividend;
        word_t divisor;
    } div_req_t;

    typedef struct packed {
        logic  done;
        word_t quotient;
    } div_rsp_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_FINAL,
        BK_SUM
    } back_state_t;

endpackage

>>> rtl/iee_front.sv
// Front end: takes characters, classifies them and holds one command
// for the queue. Depends on iee_pkg.
module iee_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           item_valid,
    output logic                           item_stall,
    input  logic [iee_pkg::CHAR_WIDTH-1:0] char_code,
    input  logic                           end_of_expression,
    output iee_pkg::cmd_t                  cmd,
    output logic                           cmd_valid,
    input  logic                           cmd_full
);
    import iee_pkg::*;

    logic cmd_valid_reg;
    logic cmd_valid_next;
    cmd_t cmd_reg;
    cmd_t cmd_next;
    cmd_t cls;
    logic is_blank;
    logic is_digit;
    logic accept;
    logic keep;
    logic push;

    // character classes
    always_comb
    begin
        is_blank = (char_code == CH_SPACE) || ((char_code >= CH_TAB) && (char_code <= CH_CR));
        is_digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);

        cls.last  = end_of_expression;
        cls.digit = DIGIT_WIDTH'(char_code - CH_ZERO);
        unique case (char_code)
            CH_PLUS:  cls.op = OP_PLUS;
            CH_MINUS: cls.op = OP_MINUS;
            CH_STAR:  cls.op = OP_TIMES;
            CH_SLASH: cls.op = OP_DIVIDE;
            default:  cls.op = OP_OTHER;
        endcase

        if (is_blank)
            cls.kind = CMD_FLUSH;
        else if (is_digit)
            cls.kind = CMD_DIGIT;
        else
            cls.kind = CMD_OPER;
    end

    // handshake: a held command only blocks while the queue is full
    assign push       = cmd_valid_reg && !cmd_full;
    assign item_stall = cmd_valid_reg && cmd_full;
    assign accept     = item_valid && !item_stall;
    // a blank only matters when it ends the expression
    assign keep       = !is_blank || end_of_expression;

    always_comb
    begin
        cmd_valid_next = cmd_valid_reg;
        cmd_next       = cmd_reg;
        if (push)
            cmd_valid_next = 1'b0;
        if (accept && keep)
        begin
            cmd_valid_next = 1'b1;
            cmd_next       = cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cmd_valid_reg <= 1'b0;
        else
            cmd_valid_reg <= cmd_valid_next;
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

    assign cmd       = cmd_reg;
    assign cmd_valid = cmd_valid_reg;

endmodule

>>> rtl/iee_cmd_fifo.sv
// Short command queue between front and back.
// Depends on iee_pkg.
module iee_cmd_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  iee_pkg::cmd_t push_data,
    output logic          full,
    input  logic          pop,
    output iee_pkg::cmd_t head,
    output logic          head_valid
);
    import iee_pkg::*;

    cmd_t                 entries_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg;
    logic [FIFO_AW-1:0]   wr_ptr_next;
    logic [FIFO_AW-1:0]   rd_ptr_reg;
    logic [FIFO_AW-1:0]   rd_ptr_next;
    logic [FIFO_AW:0]     count_reg;
    logic [FIFO_AW:0]     count_next;
    logic                 do_push;
    logic                 do_pop;

    assign full       = (count_reg == (FIFO_AW + 1)'(FIFO_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = entries_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // pointer and fill count
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entries_reg[wr_ptr_reg] <= push_data;
    end

endmodule

>>> rtl/iee_divider.sv
// Iterative signed divider, one quotient bit per cycle, truncating.
// Divisor must be nonzero. Depends on iee_pkg.
module iee_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  iee_pkg::div_req_t req,
    output iee_pkg::div_rsp_t rsp
);
    import iee_pkg::*;

    localparam int CNT_W = $clog2(DATA_WIDTH + 1);

    logic               busy_reg;
    logic               busy_next;
    logic               fix_reg;
    logic               fix_next;
    logic               done_reg;
    logic               done_next;
    logic               neg_reg;
    logic               neg_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    word_t              rem_reg;
    word_t              rem_next;
    word_t              quo_reg;
    word_t              quo_next;
    word_t              dvs_reg;
    word_t              dvs_next;
    word_t              q_out_reg;
    word_t              q_out_next;
    logic [DATA_WIDTH:0] trial;
    logic [DATA_WIDTH:0] diff;
    logic               fits;

    // one restoring step
    assign trial = {rem_reg, quo_reg[DATA_WIDTH-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = (trial >= {1'b0, dvs_reg});

    always_comb
    begin
        busy_next  = busy_reg;
        fix_next   = fix_reg;
        done_next  = 1'b0;
        neg_next   = neg_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        dvs_next   = dvs_reg;
        q_out_next = q_out_reg;

        if (req.start)
        begin
            // load magnitudes, remember the sign of the quotient
            busy_next = 1'b1;
            fix_next  = 1'b0;
            cnt_next  = '0;
            rem_next  = '0;
            neg_next  = req.dividend[DATA_WIDTH-1] ^ req.divisor[DATA_WIDTH-1];
            quo_next  = req.dividend[DATA_WIDTH-1] ? word_t'('0) - req.dividend : req.dividend;
            dvs_next  = req.divisor[DATA_WIDTH-1] ? word_t'('0) - req.divisor : req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
            quo_next = {quo_reg[DATA_WIDTH-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DATA_WIDTH - 1))
            begin
                busy_next = 1'b0;
                fix_next  = 1'b1;
            end
        end
        else if (fix_reg)
        begin
            // sign fix; most negative over minus one wraps naturally
            fix_next   = 1'b0;
            done_next  = 1'b1;
            q_out_next = neg_reg ? word_t'('0) - quo_reg : quo_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fix_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            fix_reg  <= fix_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg   <= neg_next;
        cnt_reg   <= cnt_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        dvs_reg   <= dvs_next;
        q_out_reg <= q_out_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = q_out_reg;

endmodule

>>> rtl/iee_back.sv
// Back end: runs commands against the running sum and current term,
// drives the divider and holds the result register. Depends on iee_pkg.
module iee_back (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  iee_pkg::cmd_t                          head,
    input  logic                                   head_valid,
    output logic                                   pop,
    output iee_pkg::div_req_t                      div_req,
    input  iee_pkg::div_rsp_t                      div_rsp,
    output logic                                   result_valid,
    input  logic                                   result_stall,
    output logic signed [iee_pkg::VALUE_WIDTH-1:0] value,
    output logic                                   divide_by_zero,
    output logic                                   bad_character
);
    import iee_pkg::*;

    back_state_t state_reg;
    back_state_t state_next;

    word_t sum_reg;
    word_t sum_next;
    word_t term_reg;
    word_t term_next;
    word_t pend_reg;
    word_t pend_next;
    op_t   op_reg;
    op_t   op_next;
    logic  dz_reg;
    logic  dz_next;
    logic  bc_reg;
    logic  bc_next;
    logic  last_reg;
    logic  last_next;
    logic  final_div_reg;
    logic  final_div_next;

    logic                          result_valid_reg;
    logic                          result_valid_next;
    logic signed [VALUE_WIDTH-1:0] value_reg;
    logic signed [VALUE_WIDTH-1:0] value_next;
    logic                          dzo_reg;
    logic                          dzo_next;
    logic                          bco_reg;
    logic                          bco_next;

    word_t apply_sum;
    word_t apply_term;
    logic  apply_dz;
    logic  apply_is_div;
    word_t prod;
    word_t total;
    word_t digit_acc;

    assign prod      = term_reg * pend_reg;
    assign total     = sum_reg + term_reg;
    assign digit_acc = (pend_reg << 3) + (pend_reg << 1) + word_t'(head.digit);

    // pending operator applied to the pending number
    always_comb
    begin
        apply_sum    = sum_reg;
        apply_term   = term_reg;
        apply_dz     = 1'b0;
        apply_is_div = 1'b0;
        case (op_reg)
            OP_PLUS:
            begin
                apply_sum  = sum_reg + term_reg;
                apply_term = pend_reg;
            end
            OP_MINUS:
            begin
                apply_sum  = sum_reg + term_reg;
                apply_term = word_t'('0) - pend_reg;
            end
            OP_TIMES:
                apply_term = prod;
            OP_DIVIDE:
            begin
                if (pend_reg == '0)
                begin
                    apply_term = '0;
                    apply_dz   = 1'b1;
                end
                else
                    apply_is_div = 1'b1;
            end
            default:
                apply_term = term_reg;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (head_valid)
                begin
                    case (head.kind)
                        CMD_DIGIT:
                            state_next = head.last ? BK_FINAL : BK_IDLE;
                        CMD_OPER:
                        begin
                            if (apply_is_div)
                                state_next = BK_DIV;
                            else
                                state_next = head.last ? BK_FINAL : BK_IDLE;
                        end
                        default:
                            state_next = head.last ? BK_FINAL : BK_IDLE;
                    endcase
                end
            end
            BK_DIV:
            begin
                if (div_rsp.done)
                begin
                    if (final_div_reg)
                        state_next = BK_SUM;
                    else
                        state_next = last_reg ? BK_FINAL : BK_IDLE;
                end
            end
            BK_FINAL:
                state_next = apply_is_div ? BK_DIV : BK_SUM;
            BK_SUM:
                state_next = result_valid_reg ? BK_SUM : BK_IDLE;
            default:
                state_next = BK_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        pop               = 1'b0;
        div_req.start     = 1'b0;
        div_req.dividend  = term_reg;
        div_req.divisor   = pend_reg;
        sum_next          = sum_reg;
        term_next         = term_reg;
        pend_next         = pend_reg;
        op_next           = op_reg;
        dz_next           = dz_reg;
        bc_next           = bc_reg;
        last_next         = last_reg;
        final_div_next    = final_div_reg;
        result_valid_next = result_valid_reg;
        value_next        = value_reg;
        dzo_next          = dzo_reg;
        bco_next          = bco_reg;

        // result taken
        if (result_valid_reg && !result_stall)
            result_valid_next = 1'b0;

        unique case (state_reg)
            BK_IDLE:
            begin
                if (head_valid)
                begin
                    pop            = 1'b1;
                    last_next      = head.last;
                    final_div_next = 1'b0;
                    case (head.kind)
                        CMD_DIGIT:
                            pend_next = digit_acc;
                        CMD_OPER:
                        begin
                            sum_next      = apply_sum;
                            term_next     = apply_term;
                            dz_next       = dz_reg | apply_dz;
                            pend_next     = '0;
                            op_next       = head.op;
                            bc_next       = bc_reg | (head.op == OP_OTHER);
                            div_req.start = apply_is_div;
                        end
                        default:
                            pend_next = pend_reg;
                    endcase
                end
            end
            BK_DIV:
            begin
                if (div_rsp.done)
                    term_next = div_rsp.quotient;
            end
            BK_FINAL:
            begin
                sum_next       = apply_sum;
                term_next      = apply_term;
                dz_next        = dz_reg | apply_dz;
                pend_next      = '0;
                final_div_next = 1'b1;
                div_req.start  = apply_is_div;
            end
            BK_SUM:
            begin
                // load result, then return to the cleared state
                if (!result_valid_reg)
                begin
                    result_valid_next = 1'b1;
                    value_next        = VALUE_WIDTH'($signed(total));
                    dzo_next          = dz_reg;
                    bco_next          = bc_reg;
                    sum_next          = '0;
                    term_next         = '0;
                    pend_next         = '0;
                    op_next           = OP_PLUS;
                    dz_next           = 1'b0;
                    bc_next           = 1'b0;
                end
            end
            default:
                pop = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= BK_IDLE;
            sum_reg          <= '0;
            term_reg         <= '0;
            pend_reg         <= '0;
            op_reg           <= OP_PLUS;
            dz_reg           <= 1'b0;
            bc_reg           <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            sum_reg          <= sum_next;
            term_reg         <= term_next;
            pend_reg         <= pend_next;
            op_reg           <= op_next;
            dz_reg           <= dz_next;
            bc_reg           <= bc_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg      <= last_next;
        final_div_reg <= final_div_next;
        value_reg     <= value_next;
        dzo_reg       <= dzo_next;
        bco_reg       <= bco_next;
    end

    assign result_valid   = result_valid_reg;
    assign value          = value_reg;
    assign divide_by_zero = dzo_reg;
    assign bad_character  = bco_reg;

endmodule

>>> rtl/infix_expression_evaluator_top.sv
// Top level of the infix expression evaluator: front, command queue,
// back end and divider. Depends on iee_pkg and the four submodules.
//
//   channel  | direction | handshake                 | payload
//   ---------+-----------+---------------------------+------------------------------------
//   item     | in        | item_valid / item_stall   | char_code, end_of_expression
//   result   | out       | result_valid / result_stall | value, divide_by_zero, bad_character
//
// Digits and + - * are handled in the back end's idle state; blanks are dropped in the
// front unless they end the expression. A division by a nonzero value goes through
// the 32-step divider.
// The last item adds a final apply state (or a divide) and a sum state.
// The front keeps taking characters until the four-entry queue fills and its held command waits.
// A result waits in its output register; the next result loads only after
// it is taken. No clearing pass after reset.
module infix_expression_evaluator_top (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   item_valid,
    output logic                                   item_stall,
    input  logic [iee_pkg::CHAR_WIDTH-1:0]         char_code,
    input  logic                                   end_of_expression,
    output logic                                   result_valid,
    input  logic                                   result_stall,
    output logic signed [iee_pkg::VALUE_WIDTH-1:0] value,
    output logic                                   divide_by_zero,
    output logic                                   bad_character
);
    import iee_pkg::*;

    cmd_t     front_cmd;
    logic     front_cmd_valid;
    logic     queue_full;
    cmd_t     queue_head;
    logic     queue_head_valid;
    logic     queue_pop;
    div_req_t div_req;
    div_rsp_t div_rsp;

    iee_front u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .item_valid        (item_valid),
        .item_stall        (item_stall),
        .char_code         (char_code),
        .end_of_expression (end_of_expression),
        .cmd               (front_cmd),
        .cmd_valid         (front_cmd_valid),
        .cmd_full          (queue_full)
    );

    iee_cmd_fifo u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (front_cmd_valid),
        .push_data  (front_cmd),
        .full       (queue_full),
        .pop        (queue_pop),
        .head       (queue_head),
        .head_valid (queue_head_valid)
    );

    iee_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head           (queue_head),
        .head_valid     (queue_head_valid),
        .pop            (queue_pop),
        .div_req        (div_req),
        .div_rsp        (div_rsp),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .value          (value),
        .divide_by_zero (divide_by_zero),
        .bad_character  (bad_character)
    );

    iee_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

endmodule

>>> rtl/iee_checker.sv
// Port-level checks of the infix expression evaluator, bound to the top.
// Depends on infix_expression_evaluator_top_defines.svh.
`include "infix_expression_evaluator_top_defines.svh"

module iee_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        item_stall,
    input logic        result_valid,
    input logic        result_stall,
    input logic [31:0] value,
    input logic        divide_by_zero,
    input logic        bad_character
);

    // a stalled result stays offered
    `IEE_ASSERT(a_result_hold, result_valid && result_stall |=> result_valid, "result dropped while stalled")

    // a stalled result keeps its payload
    `IEE_ASSERT(a_result_stable, result_valid && result_stall |=> $stable(value) && $stable(divide_by_zero) && $stable(bad_character), "result payload changed while stalled")

    // results never come back to back: the output register refills only after it has gone empty
    `IEE_ASSERT(a_result_gap, result_valid && !result_stall |=> !result_valid, "result offered right after one was taken")

    // no result and an open input while in reset
    `IEE_ASSERT_ALWAYS(a_reset_quiet, !rst_n |-> !result_valid && !item_stall, "outputs active during reset")

endmodule

bind infix_expression_evaluator_top iee_checker u_checker (.*);
